>>> rtl/core/apsp_pkg.sv
// shared types and constants for the all-pairs shortest path block
`timescale 1ns / 1ps

package apsp_pkg;

  localparam int MaxVertices = 64;
  localparam int VidBits = 7;
  localparam int AddrBits = 12;
  localparam int IdxBits = 6;
  localparam int DistBits = 23;
  localparam int CostBits = 16;
  localparam logic [DistBits-1:0] DistUnreach = 23'h400000;
  localparam logic [DistBits-1:0] DistMaxCost = 23'h3FFFFF;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EDGE2,
    ST_QUERY,
    ST_QWAIT,
    ST_RIK,
    ST_RKJ,
    ST_RIJ,
    ST_RWR
  } apsp_state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_EDGE_FWD,
    OP_EDGE_REV,
    OP_QUERY,
    OP_RD_IK,
    OP_RD_KJ,
    OP_RD_IJ
  } apsp_op_t;

  typedef struct packed {
    apsp_op_t             op;
    logic                 write_relax;
    logic                 capture_in;
    logic                 out_load;
    logic [AddrBits-1:0]  clr_addr;
    logic [IdxBits-1:0]   ki;
    logic [IdxBits-1:0]   ii;
    logic [IdxBits-1:0]   ji;
  } apsp_cmd_t;

  typedef struct packed {
    logic ik_unreach;
    logic edge_valid;
  } apsp_status_t;

endpackage

>>> rtl/core/all_pairs_shortest_path.sv
// top level of the all-pairs shortest path block
`timescale 1ns / 1ps
// channel      dir  beat content
// s_axis       in   request: type, vertices, cost, direction, last
// m_axis       out  query result: cost, predecessor, reachable
// cfg          in   vertex_count
// after reset a pass over every address clears the memories; no beat is taken meanwhile
// the first edge after a relaxation first reruns the clearing pass
// input waits while the result is full
// the last edge starts the relaxation: a read of i,k per row, then reads of k,j and i,j and a write per inner step
// memory reads are registered

module all_pairs_shortest_path (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // src_vertex, dst_vertex, edge_cost, is_directed
  input  logic        s_axis_tuser,   // req_type
  input  logic        s_axis_tlast,   // last_edge
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // path_cost, prev_vertex, reachable
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);

  apsp_pkg::apsp_cmd_t cmd;
  apsp_pkg::apsp_status_t status;
  logic [6:0] vcount, n_act;
  logic out_set;
  logic [21:0] q_cost;
  logic [6:0] q_prev;
  logic q_reach;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) vcount <= 7'd64;
    else if (cfg_valid) vcount <= cfg_data;
  end
  assign n_act = (vcount == 7'd0) ? 7'd1 : (vcount > 7'd64) ? 7'd64 : vcount;

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (out_set) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end
  assign m_axis_tdata = {2'd0, q_reach, q_prev, q_cost};

  apsp_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .s_valid(s_axis_tvalid), .s_req_type(s_axis_tuser),
    .s_is_directed(s_axis_tdata[30]), .s_last(s_axis_tlast),
    .s_ready(s_axis_tready), .out_free(!m_axis_tvalid), .out_set(out_set),
    .n_act(n_act), .status(status), .cmd(cmd)
  );

  apsp_datapath u_dp (
    .clk(clk), .cmd(cmd), .n_act(n_act),
    .in_req_type(s_axis_tuser), .in_src(s_axis_tdata[6:0]),
    .in_dst(s_axis_tdata[13:7]), .in_cost(s_axis_tdata[29:14]),
    .status(status), .q_cost(q_cost), .q_prev(q_prev), .q_reach(q_reach)
  );

`ifndef SYNTH
  a_no_out_when_full: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_reach_cost: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[29] |-> m_axis_tdata[28:0] == 29'd0)
    else $error("unreachable result not zero");
`endif

endmodule

>>> rtl/core/apsp_datapath.sv
// distance and predecessor memories with the relaxation arithmetic
`timescale 1ns / 1ps

module apsp_datapath (
  input  logic                     clk,
  input  apsp_pkg::apsp_cmd_t      cmd,
  input  logic [6:0]               n_act,
  input  logic                     in_req_type,
  input  logic [6:0]               in_src,
  input  logic [6:0]               in_dst,
  input  logic [15:0]              in_cost,
  output apsp_pkg::apsp_status_t   status,
  output logic [21:0]              q_cost,
  output logic [6:0]               q_prev,
  output logic                     q_reach
);

  logic [apsp_pkg::DistBits-1:0] dmem [apsp_pkg::MaxVertices*apsp_pkg::MaxVertices];
  logic [6:0] pmem [apsp_pkg::MaxVertices*apsp_pkg::MaxVertices];

  logic [6:0] src, dst;
  logic [15:0] cost;
  logic req;
  logic [apsp_pkg::DistBits-1:0] rd_d;
  logic [6:0] rd_p;
  logic [apsp_pkg::DistBits-1:0] dik, dkj, sum;
  logic [6:0] pkj;
  logic [apsp_pkg::AddrBits-1:0] raddr, waddr;
  logic we;
  logic [apsp_pkg::DistBits-1:0] wd;
  logic [6:0] wp;
  logic [apsp_pkg::DistBits:0] raw_sum;
  logic [5:0] s0, d0;
  logic valid;
  logic [apsp_pkg::DistBits-1:0] ec;

  assign s0 = 6'(src - 7'd1);
  assign d0 = 6'(dst - 7'd1);
  assign valid = (src != 7'd0) && (dst != 7'd0) && (src <= n_act) && (dst <= n_act);
  assign status.edge_valid = valid;
  assign status.ik_unreach = dik[apsp_pkg::DistBits-1];
  assign ec = {7'd0, cost};

  always_ff @(posedge clk) begin
    if (cmd.capture_in) begin
      src <= in_src;
      dst <= in_dst;
      cost <= in_cost;
      req <= in_req_type;
    end
  end

  always_comb begin
    raddr = '0;
    unique case (cmd.op)
      apsp_pkg::OP_EDGE_FWD, apsp_pkg::OP_QUERY: raddr = {s0, d0};
      apsp_pkg::OP_EDGE_REV: raddr = {d0, s0};
      apsp_pkg::OP_RD_IK: raddr = {cmd.ii, cmd.ki};
      apsp_pkg::OP_RD_KJ: raddr = {cmd.ki, cmd.ji};
      apsp_pkg::OP_RD_IJ: raddr = {cmd.ii, cmd.ji};
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_d <= dmem[raddr];
    rd_p <= pmem[raddr];
  end

  // registered tap of the previous read plus op of that read
  apsp_pkg::apsp_op_t op_d;
  logic [apsp_pkg::AddrBits-1:0] addr_d;
  always_ff @(posedge clk) begin
    op_d <= cmd.op;
    addr_d <= raddr;
    if (op_d == apsp_pkg::OP_RD_IK) dik <= rd_d;
    if (op_d == apsp_pkg::OP_RD_KJ) begin
      dkj <= rd_d;
      pkj <= rd_p;
    end
  end

  assign raw_sum = {1'b0, dik} + {1'b0, dkj};
  assign sum = (raw_sum > {1'b0, apsp_pkg::DistMaxCost}) ? apsp_pkg::DistMaxCost
                                                         : raw_sum[apsp_pkg::DistBits-1:0];

  always_comb begin
    we = 1'b0;
    waddr = addr_d;
    wd = ec;
    wp = src;
    if (cmd.op == apsp_pkg::OP_CLEAR) begin
      we = 1'b1;
      waddr = cmd.clr_addr;
      wd = (cmd.clr_addr[11:6] == cmd.clr_addr[5:0]) ? '0 : apsp_pkg::DistUnreach;
      wp = (cmd.clr_addr[11:6] == cmd.clr_addr[5:0]) ? {1'b0, cmd.clr_addr[5:0]} + 7'd1
                                                     : 7'd0;
    end else if (cmd.write_relax) begin
      waddr = addr_d;
      wd = sum;
      wp = pkj;
      we = !dkj[apsp_pkg::DistBits-1] && (sum < rd_d);
    end else if (!req && valid &&
                 (op_d == apsp_pkg::OP_EDGE_FWD || op_d == apsp_pkg::OP_EDGE_REV)) begin
      we = ec < rd_d;
      wp = (op_d == apsp_pkg::OP_EDGE_FWD) ? src : dst;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      dmem[waddr] <= wd;
      pmem[waddr] <= wp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      q_reach <= valid && !rd_d[apsp_pkg::DistBits-1];
      q_cost <= (valid && !rd_d[apsp_pkg::DistBits-1]) ? rd_d[21:0] : 22'd0;
      q_prev <= (valid && !rd_d[apsp_pkg::DistBits-1]) ? rd_p : 7'd0;
    end
  end

endmodule

>>> rtl/core/apsp_ctrl.sv
// sequencer for loading, clearing, querying and relaxation
`timescale 1ns / 1ps

module apsp_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_valid,
  input  logic                    s_req_type,
  input  logic                    s_is_directed,
  input  logic                    s_last,
  output logic                    s_ready,
  input  logic                    out_free,
  output logic                    out_set,
  input  logic [6:0]              n_act,
  input  apsp_pkg::apsp_status_t  status,
  output apsp_pkg::apsp_cmd_t     cmd
);

  apsp_pkg::apsp_state_t state, state_next;
  logic [11:0] ctr, ctr_next;
  logic [5:0] k, i, j, k_next, i_next, j_next;
  logic computed, computed_next, dir, dir_next, last, last_next;
  logic pend_clear, pend_clear_next;
  logic [5:0] nm1;

  assign nm1 = 6'(n_act - 7'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= apsp_pkg::ST_CLEAR;
      ctr <= '0;
      computed <= 1'b0;
      pend_clear <= 1'b0;
      k <= '0; i <= '0; j <= '0;
      dir <= 1'b0; last <= 1'b0;
    end else begin
      state <= state_next;
      ctr <= ctr_next;
      computed <= computed_next;
      pend_clear <= pend_clear_next;
      k <= k_next; i <= i_next; j <= j_next;
      dir <= dir_next; last <= last_next;
    end
  end

  always_comb begin
    state_next = state;
    ctr_next = ctr;
    computed_next = computed;
    pend_clear_next = pend_clear;
    k_next = k; i_next = i; j_next = j;
    dir_next = dir; last_next = last;
    s_ready = 1'b0;
    out_set = 1'b0;
    cmd = '0;
    cmd.op = apsp_pkg::OP_NONE;
    cmd.clr_addr = ctr;
    cmd.ki = k; cmd.ii = i; cmd.ji = j;
    unique case (state)
      apsp_pkg::ST_CLEAR: begin
        cmd.op = apsp_pkg::OP_CLEAR;
        ctr_next = ctr + 12'd1;
        if (ctr == 12'hFFF) begin
          computed_next = 1'b0;
          if (pend_clear) begin
            pend_clear_next = 1'b0;
            cmd.op = apsp_pkg::OP_CLEAR;
            state_next = apsp_pkg::ST_EDGE2;
          end else begin
            state_next = apsp_pkg::ST_IDLE;
          end
        end
      end
      apsp_pkg::ST_IDLE: begin
        s_ready = out_free;
        cmd.capture_in = 1'b1;
        if (s_valid && out_free) begin
          dir_next = s_is_directed;
          last_next = s_last;
          if (s_req_type) begin
            state_next = apsp_pkg::ST_QUERY;
          end else if (computed) begin
            pend_clear_next = 1'b1;
            ctr_next = '0;
            state_next = apsp_pkg::ST_CLEAR;
          end else begin
            state_next = apsp_pkg::ST_EDGE2;
          end
        end
      end
      apsp_pkg::ST_EDGE2: begin
        // fwd read now, write next cycle; reverse, for undirected edges only, in step two
        if (ctr == 12'd0) begin
          cmd.op = apsp_pkg::OP_EDGE_FWD;
          ctr_next = 12'd1;
        end else if (ctr == 12'd1) begin
          cmd.op = dir ? apsp_pkg::OP_NONE : apsp_pkg::OP_EDGE_REV;
          ctr_next = 12'd2;
        end else begin
          ctr_next = '0;
          if (last) begin
            k_next = '0; i_next = '0; j_next = '0;
            state_next = apsp_pkg::ST_RIK;
          end else begin
            state_next = apsp_pkg::ST_IDLE;
          end
        end
      end
      apsp_pkg::ST_QUERY: begin
        cmd.op = apsp_pkg::OP_QUERY;
        state_next = apsp_pkg::ST_QWAIT;
      end
      apsp_pkg::ST_QWAIT: begin
        cmd.out_load = 1'b1;
        out_set = 1'b1;
        state_next = apsp_pkg::ST_IDLE;
      end
      apsp_pkg::ST_RIK: begin
        cmd.op = apsp_pkg::OP_RD_IK;
        state_next = apsp_pkg::ST_RKJ;
      end
      apsp_pkg::ST_RKJ: begin
        cmd.op = apsp_pkg::OP_RD_KJ;
        state_next = apsp_pkg::ST_RIJ;
      end
      apsp_pkg::ST_RIJ: begin
        cmd.op = apsp_pkg::OP_RD_IJ;
        state_next = apsp_pkg::ST_RWR;
      end
      apsp_pkg::ST_RWR: begin
        cmd.write_relax = !status.ik_unreach;
        if (j != nm1) begin
          j_next = j + 6'd1;
          state_next = apsp_pkg::ST_RKJ;
        end else begin
          j_next = '0;
          if (i != nm1) begin
            i_next = i + 6'd1;
            state_next = apsp_pkg::ST_RIK;
          end else begin
            i_next = '0;
            if (k != nm1) begin
              k_next = k + 6'd1;
              state_next = apsp_pkg::ST_RIK;
            end else begin
              k_next = '0;
              computed_next = 1'b1;
              state_next = apsp_pkg::ST_IDLE;
            end
          end
        end
      end
      default: state_next = apsp_pkg::ST_IDLE;
    endcase
  end

endmodule
